// ===== sv/binary_min_heap_priority_queue_top_assert.svh =====
// Assertion macros used by the checker file of the priority queue.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BMHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("priority queue check failed");

// Next-cycle implication, checked outside reset.
`define BMHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("priority queue check failed");

`endif

// ===== sv/bmhpq_pkg.sv =====
// Package with the types, sizes and codes of the min-heap priority queue.
`default_nettype none
package bmhpq_pkg;
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 11;
    localparam int ID_W     = 16;
    localparam int KEY_W    = 32;
    localparam int ENT_W    = ID_W + KEY_W;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 64;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_EXTRACT  = 2'd1;
    localparam logic [1:0] OP_DECREASE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_NOT_LOWER = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_UP, S_UP_W, S_EX_ROOT, S_EX_LAST,
        S_DN, S_DN_L, S_DN_R, S_DN_C, S_SEARCH, S_DONE
    } t_state;
endpackage
`default_nettype wire

// ===== sv/bmhpq_ram.sv =====
// Heap entry memory with one write port and one registered read port.
`default_nettype none
module bmhpq_ram (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire [bmhpq_pkg::ADDR_W-1:0]  i_waddr,
    input  wire bmhpq_pkg::t_entry       i_wdata,
    input  wire [bmhpq_pkg::ADDR_W-1:0]  i_raddr,
    output bmhpq_pkg::t_entry            o_rdata
);
    bmhpq_pkg::t_entry mem [bmhpq_pkg::CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/binary_min_heap_priority_queue_top.sv =====
// Each transaction runs to completion before the next is accepted. Full, empty and unused ops
// go straight to the result; insert climbs the heap, extract moves the last entry to the root
// and sinks it, and decrease key searches the held entries in order, then climbs from the
// found slot when the new key is lower.
// Reset clears the entry count and control state; the entry memory is not cleared.
`default_nettype none
module binary_min_heap_priority_queue_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // func[1:0], item_id[17:2], priority_key[49:18], zero fill
    input  wire [bmhpq_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // out_id[15:0], out_key[47:16], status[50:48], now_empty[51],
    // entry_count[62:52], zero fill
    output logic [bmhpq_pkg::OUT_W-1:0]  m_axis_tdata
);
    localparam int AW = bmhpq_pkg::ADDR_W;
    localparam int CW = bmhpq_pkg::CNT_W;

    bmhpq_pkg::t_state r_state, n_state;
    logic [1:0]          r_func, n_func;
    bmhpq_pkg::t_entry   r_in, n_in;
    bmhpq_pkg::t_entry   r_cur, n_cur;
    bmhpq_pkg::t_entry   r_ch, n_ch;
    bmhpq_pkg::t_entry   r_res, n_res;
    logic [AW-1:0]       r_pos, n_pos;
    logic [AW-1:0]       r_cidx, n_cidx;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_sidx, n_sidx;
    logic                r_pend, n_pend;
    logic [2:0]          r_status, n_status;
    logic                r_ovalid, n_ovalid;
    logic [bmhpq_pkg::OUT_W-1:0] r_odata, n_odata;

    logic                we;
    logic [AW-1:0]       waddr, raddr;
    bmhpq_pkg::t_entry   wdata, rdata;
    logic [AW+1:0]       lidx, ridx, nfill;
    logic [AW-1:0]       par;
    logic                up_swap, dn_swap, hit, fire_out;

    bmhpq_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign s_axis_tready = (r_state == bmhpq_pkg::S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign lidx     = {1'b0, r_pos, 1'b1};
    assign ridx     = lidx + (AW+2)'(1);
    assign nfill    = (AW+2)'(r_count);
    assign par      = (r_pos - AW'(1)) >> 1;
    assign up_swap  = r_cur.key < rdata.key;
    assign dn_swap  = r_ch.key < r_cur.key;
    assign hit      = r_pend && (rdata.id == r_in.id);
    assign fire_out = !r_ovalid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bmhpq_pkg::S_IDLE: begin
                if (s_axis_tvalid) n_state = bmhpq_pkg::S_DISPATCH;
            end
            bmhpq_pkg::S_DISPATCH: begin
                case (r_func)
                    bmhpq_pkg::OP_INSERT: begin
                        n_state = (r_count == CW'(bmhpq_pkg::CAPACITY)) ?
                                  bmhpq_pkg::S_DONE : bmhpq_pkg::S_UP;
                    end
                    bmhpq_pkg::OP_EXTRACT: begin
                        n_state = (r_count == '0) ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_EX_ROOT;
                    end
                    bmhpq_pkg::OP_DECREASE: n_state = bmhpq_pkg::S_SEARCH;
                    default: n_state = bmhpq_pkg::S_DONE;
                endcase
            end
            bmhpq_pkg::S_UP: begin
                n_state = (r_pos == '0) ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_UP_W;
            end
            bmhpq_pkg::S_UP_W: n_state = up_swap ? bmhpq_pkg::S_UP : bmhpq_pkg::S_DONE;
            bmhpq_pkg::S_EX_ROOT: n_state = bmhpq_pkg::S_EX_LAST;
            bmhpq_pkg::S_EX_LAST: n_state = bmhpq_pkg::S_DN;
            bmhpq_pkg::S_DN: begin
                n_state = (lidx >= nfill) ? bmhpq_pkg::S_DONE : bmhpq_pkg::S_DN_L;
            end
            bmhpq_pkg::S_DN_L: begin
                n_state = (ridx < nfill) ? bmhpq_pkg::S_DN_R : bmhpq_pkg::S_DN_C;
            end
            bmhpq_pkg::S_DN_R: n_state = bmhpq_pkg::S_DN_C;
            bmhpq_pkg::S_DN_C: n_state = dn_swap ? bmhpq_pkg::S_DN : bmhpq_pkg::S_DONE;
            bmhpq_pkg::S_SEARCH: begin
                if (hit) begin
                    n_state = (r_in.key < rdata.key) ? bmhpq_pkg::S_UP : bmhpq_pkg::S_DONE;
                end else if (!r_pend && r_idx >= r_count) begin
                    n_state = bmhpq_pkg::S_DONE;
                end
            end
            bmhpq_pkg::S_DONE: begin
                if (fire_out) n_state = bmhpq_pkg::S_IDLE;
            end
            default: n_state = bmhpq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_func   = r_func;
        n_in     = r_in;
        n_cur    = r_cur;
        n_ch     = r_ch;
        n_res    = r_res;
        n_pos    = r_pos;
        n_cidx   = r_cidx;
        n_count  = r_count;
        n_idx    = r_idx;
        n_sidx   = r_sidx;
        n_pend   = 1'b0;
        n_status = r_status;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        we       = 1'b0;
        waddr    = r_pos;
        wdata    = r_cur;
        raddr    = '0;
        unique case (r_state)
            bmhpq_pkg::S_IDLE: begin
                n_func   = s_axis_tdata[1:0];
                n_in.id  = s_axis_tdata[17:2];
                n_in.key = s_axis_tdata[49:18];
                n_res    = '0;
                n_status = bmhpq_pkg::ST_OK;
            end
            bmhpq_pkg::S_DISPATCH: begin
                n_idx = '0;
                case (r_func)
                    bmhpq_pkg::OP_INSERT: begin
                        if (r_count == CW'(bmhpq_pkg::CAPACITY)) begin
                            n_status = bmhpq_pkg::ST_FULL;
                        end else begin
                            n_cur   = r_in;
                            n_pos   = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                        end
                    end
                    bmhpq_pkg::OP_EXTRACT: begin
                        if (r_count == '0) n_status = bmhpq_pkg::ST_EMPTY;
                        raddr = '0;
                    end
                    bmhpq_pkg::OP_DECREASE: n_status = bmhpq_pkg::ST_NOT_FOUND;
                    default: ;
                endcase
            end
            bmhpq_pkg::S_UP: begin
                if (r_pos == '0) we = 1'b1;
                raddr = par;
            end
            bmhpq_pkg::S_UP_W: begin
                we = 1'b1;
                if (up_swap) begin
                    wdata = rdata;
                    n_pos = par;
                end
            end
            bmhpq_pkg::S_EX_ROOT: begin
                n_res = rdata;
                raddr = AW'(r_count - CW'(1));
            end
            bmhpq_pkg::S_EX_LAST: begin
                n_cur   = rdata;
                n_pos   = '0;
                n_count = r_count - CW'(1);
            end
            bmhpq_pkg::S_DN: begin
                if (lidx >= nfill) we = 1'b1;
                raddr = lidx[AW-1:0];
            end
            bmhpq_pkg::S_DN_L: begin
                n_ch   = rdata;
                n_cidx = lidx[AW-1:0];
                raddr  = ridx[AW-1:0];
            end
            bmhpq_pkg::S_DN_R: begin
                if (rdata.key < r_ch.key) begin
                    n_ch   = rdata;
                    n_cidx = ridx[AW-1:0];
                end
            end
            bmhpq_pkg::S_DN_C: begin
                we = 1'b1;
                if (dn_swap) begin
                    wdata = r_ch;
                    n_pos = r_cidx;
                end
            end
            bmhpq_pkg::S_SEARCH: begin
                raddr = r_idx[AW-1:0];
                if (hit) begin
                    if (r_in.key < rdata.key) begin
                        n_status = bmhpq_pkg::ST_OK;
                        n_cur    = r_in;
                        n_pos    = r_sidx;
                    end else begin
                        n_status = bmhpq_pkg::ST_NOT_LOWER;
                    end
                end else if (r_idx < r_count) begin
                    n_pend = 1'b1;
                    n_sidx = r_idx[AW-1:0];
                    n_idx  = r_idx + CW'(1);
                end
            end
            bmhpq_pkg::S_DONE: begin
                if (fire_out) begin
                    n_ovalid = 1'b1;
                    n_odata  = {1'b0, r_count, (r_count == '0), r_status, r_res.key, r_res.id};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bmhpq_pkg::S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_in     <= n_in;
        r_cur    <= n_cur;
        r_ch     <= n_ch;
        r_res    <= n_res;
        r_pos    <= n_pos;
        r_cidx   <= n_cidx;
        r_idx    <= n_idx;
        r_sidx   <= n_sidx;
        r_status <= n_status;
        r_odata  <= n_odata;
    end
endmodule
`default_nettype wire

// ===== sv/bmhpq_chk.sv =====
// Port-level checker for the priority queue, bound to the top level.
`default_nettype none
`include "binary_min_heap_priority_queue_top_assert.svh"
module bmhpq_chk (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [bmhpq_pkg::OUT_W-1:0]   m_axis_tdata
);
    `BMHPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `BMHPQ_ASSERT_NOW(a_count_max, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[62:52] <= 11'd1024)
    `BMHPQ_ASSERT_NOW(a_empty_flag, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[51] == (m_axis_tdata[62:52] == 11'd0))
    `BMHPQ_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[50:48] == bmhpq_pkg::ST_EMPTY, m_axis_tdata[47:0] == 48'd0 && m_axis_tdata[51])
endmodule

bind binary_min_heap_priority_queue_top bmhpq_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== sim/binary_min_heap_priority_queue_top_tb.sv =====
// Self-checking testbench for the min-heap priority queue with a built-in heap predictor.
`timescale 1ns / 1ps
module binary_min_heap_priority_queue_top_tb;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAX_CYCLES = 3000000;
    localparam int LONG_HOLD = 400;
    localparam int IDW = bmhpq_pkg::ID_W;

    typedef struct packed {
        logic [bmhpq_pkg::ID_W-1:0]  id;
        logic [bmhpq_pkg::KEY_W-1:0] key;
        logic [2:0]                  status;
        logic                        now_empty;
        logic [bmhpq_pkg::CNT_W-1:0] count;
    } t_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [bmhpq_pkg::IN_W-1:0]  s_axis_tdata;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [bmhpq_pkg::OUT_W-1:0] m_axis_tdata;

    bmhpq_pkg::t_entry heap_model [bmhpq_pkg::CAPACITY];
    int      heap_fill;
    t_result pending_results [$];
    int      error_count;
    longint  cycle_count;
    bit      hold_start = 1'b0;
    bit      hold_seen = 1'b0;
    int      hold_cycles = 0;

    binary_min_heap_priority_queue_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic void swap_entries(int a, int b);
        bmhpq_pkg::t_entry t;
        t = heap_model[a];
        heap_model[a] = heap_model[b];
        heap_model[b] = t;
    endfunction

    function automatic void bubble_up(int pos);
        int par;
        while (pos > 0) begin
            par = (pos - 1) / 2;
            if (heap_model[pos].key < heap_model[par].key) begin
                swap_entries(pos, par);
                pos = par;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void bubble_down(int pos);
        int l;
        int c;
        forever begin
            l = 2 * pos + 1;
            if (l >= heap_fill) break;
            c = l;
            if (l + 1 < heap_fill && heap_model[l+1].key < heap_model[l].key) c = l + 1;
            if (heap_model[c].key < heap_model[pos].key) begin
                swap_entries(pos, c);
                pos = c;
            end else begin
                break;
            end
        end
    endfunction

    function automatic t_result apply_heap_op(logic [1:0] op, logic [bmhpq_pkg::ID_W-1:0] id,
                                              logic [bmhpq_pkg::KEY_W-1:0] key);
        t_result r;
        r = '0;
        r.status = bmhpq_pkg::ST_OK;
        case (op)
            bmhpq_pkg::OP_INSERT: begin
                if (heap_fill >= bmhpq_pkg::CAPACITY) begin
                    r.status = bmhpq_pkg::ST_FULL;
                end else begin
                    heap_model[heap_fill] = '{id: id, key: key};
                    heap_fill++;
                    bubble_up(heap_fill - 1);
                end
            end
            bmhpq_pkg::OP_EXTRACT: begin
                if (heap_fill == 0) begin
                    r.status = bmhpq_pkg::ST_EMPTY;
                end else begin
                    r.id = heap_model[0].id;
                    r.key = heap_model[0].key;
                    heap_model[0] = heap_model[heap_fill-1];
                    heap_fill--;
                    bubble_down(0);
                end
            end
            bmhpq_pkg::OP_DECREASE: begin
                r.status = bmhpq_pkg::ST_NOT_FOUND;
                for (int i = 0; i < heap_fill; i++) begin
                    if (heap_model[i].id == id) begin
                        if (key < heap_model[i].key) begin
                            heap_model[i].key = key;
                            bubble_up(i);
                            r.status = bmhpq_pkg::ST_OK;
                        end else begin
                            r.status = bmhpq_pkg::ST_NOT_LOWER;
                        end
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.now_empty = (heap_fill == 0);
        r.count = heap_fill[bmhpq_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic send_item(logic [1:0] op, logic [bmhpq_pkg::ID_W-1:0] id,
                             logic [bmhpq_pkg::KEY_W-1:0] key, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(bmhpq_pkg::IN_W-50){1'b0}}, key, id, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(apply_heap_op(op, id, key));
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{id: m_axis_tdata[15:0], key: m_axis_tdata[47:16],
                    status: m_axis_tdata[50:48], now_empty: m_axis_tdata[51],
                    count: m_axis_tdata[62:52]};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.id !== want.id) begin
                    $display("%0t: out_id expected %h actual %h", $time, want.id, got.id);
                    error_count++;
                end
                if (got.key !== want.key) begin
                    $display("%0t: out_key expected %h actual %h", $time, want.key, got.key);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                    error_count++;
                end
                if (got.now_empty !== want.now_empty) begin
                    $display("%0t: now_empty expected %0d actual %0d", $time,
                             want.now_empty, got.now_empty);
                    error_count++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d", $time,
                             want.count, got.count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_start != hold_seen) begin
            hold_seen <= hold_start;
            hold_cycles <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready || !m_axis_tready) begin
            if ($urandom_range(0, 2) == 0) begin
                hold_cycles <= $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_corner_cases();
        send_item(bmhpq_pkg::OP_EXTRACT, 16'h0, 32'h0);
        send_item(bmhpq_pkg::OP_DECREASE, 16'h5, 32'h1);
        send_item(OP_UNUSED, 16'hFFFF, 32'hFFFFFFFF);
        send_item(bmhpq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFFFFFF);
        send_item(bmhpq_pkg::OP_INSERT, 16'h0000, 32'h00000000);
        send_item(bmhpq_pkg::OP_INSERT, 16'h1234, 32'h80000000);
        send_item(bmhpq_pkg::OP_INSERT, 16'h1234, 32'h80000000);
        send_item(bmhpq_pkg::OP_INSERT, 16'h0042, 32'h80000000);
        send_item(bmhpq_pkg::OP_DECREASE, 16'h1234, 32'h90000000);
        send_item(bmhpq_pkg::OP_DECREASE, 16'h1234, 32'h80000000);
        send_item(bmhpq_pkg::OP_DECREASE, 16'h1234, 32'h00000001);
        send_item(bmhpq_pkg::OP_DECREASE, 16'hFFFF, 32'h00000000);
        send_item(bmhpq_pkg::OP_DECREASE, 16'h7777, 32'h00000000);
        send_item(OP_UNUSED, 16'h0, 32'h0);
        repeat (7) send_item(bmhpq_pkg::OP_EXTRACT, 16'hFFFF, 32'hFFFFFFFF);
    endtask

    task automatic test_fill_to_capacity();
        wait_drained();
        hold_start = !hold_start;
        for (int i = 0; i < bmhpq_pkg::CAPACITY; i++)
            send_item(bmhpq_pkg::OP_INSERT, i[bmhpq_pkg::ID_W-1:0], $urandom(), i < 40);
        send_item(bmhpq_pkg::OP_INSERT, 16'hABCD, 32'h0);
        send_item(bmhpq_pkg::OP_DECREASE, 16'h03FF, 32'h0);
        wait_drained();
        for (int i = 0; i < 300; i++)
            send_item(bmhpq_pkg::OP_EXTRACT, IDW'($urandom()), $urandom(), 1);
        wait_drained();
    endtask

    task automatic test_random_mix(int n_items);
        logic [1:0]                  op;
        logic [bmhpq_pkg::ID_W-1:0]  id;
        logic [bmhpq_pkg::KEY_W-1:0] key;
        int                          pick;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) op = bmhpq_pkg::OP_INSERT;
            else if (pick < 75) op = bmhpq_pkg::OP_EXTRACT;
            else if (pick < 97) op = bmhpq_pkg::OP_DECREASE;
            else op = OP_UNUSED;
            if (op == bmhpq_pkg::OP_DECREASE && heap_fill > 0 && $urandom_range(0, 3) != 0)
                id = heap_model[$urandom_range(0, heap_fill - 1)].id;
            else if ($urandom_range(0, 4) == 0)
                id = IDW'($urandom());
            else
                id = IDW'($urandom_range(0, 31));
            case ($urandom_range(0, 3))
                0: key = $urandom();
                1: key = $urandom_range(0, 15);
                2: key = {2'($urandom_range(0, 3)), 30'h0} | $urandom_range(0, 255);
                default: key = 32'hFFFFFFFF - $urandom_range(0, 15);
            endcase
            if (op == bmhpq_pkg::OP_DECREASE && id < 32 && heap_fill > 0 &&
                $urandom_range(0, 1))
                key = $urandom_range(0, 3);
            send_item(op, id, key, n % 200 < 30);
            if (n % 250 == 249) wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        heap_fill = 0;
        error_count = 0;
        cycle_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_cases();
        test_fill_to_capacity();
        test_random_mix(350);
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== binary_min_heap_priority_queue_top.f =====
+incdir+sv
sv/bmhpq_pkg.sv
sv/bmhpq_ram.sv
sv/binary_min_heap_priority_queue_top.sv
sv/bmhpq_chk.sv
sim/binary_min_heap_priority_queue_top_tb.sv
